// ===== rtl/core/prs80_pkg.sv =====
// shared types, constants and cipher layer functions for the present-80 encrypt unit
package prs80_pkg;

  localparam int BLOCK_W  = 64;
  localparam int KEY_W    = 80;
  localparam int KEY_HI_W = KEY_W - BLOCK_W;
  localparam int RC_W     = 5;
  localparam int NIBBLES  = BLOCK_W / 4;
  localparam int ROUNDS_DEFAULT = 31;

  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 4;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [RC_W-1:0]    rc_t;

  typedef enum logic {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } reg_idx_t;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      4'hF: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic block_t sub_layer(input block_t x);
    block_t y;
    for (int n = 0; n < NIBBLES; n++) begin
      y[4*n +: 4] = sbox(x[4*n +: 4]);
    end
    return y;
  endfunction

  // bit i moves to 16*i mod 63, the top bit stays put
  function automatic block_t perm_layer(input block_t x);
    block_t y;
    for (int b = 0; b < BLOCK_W; b++) begin
      if (b == BLOCK_W - 1) begin
        y[BLOCK_W-1] = x[b];
      end else begin
        y[(16 * b) % (BLOCK_W - 1)] = x[b];
      end
    end
    return y;
  endfunction

endpackage

// ===== rtl/core/prs80_round.sv =====
// one present-80 round: key add, s-box layer, permutation and key schedule step
module prs80_round (
  input  prs80_pkg::block_t state_in,
  input  prs80_pkg::key_t   key_in,
  input  prs80_pkg::rc_t    rc,
  output prs80_pkg::block_t round_out,
  output prs80_pkg::key_t   key_out
);
  import prs80_pkg::*;

  block_t mixed;
  key_t   rot;

  assign mixed     = state_in ^ key_in[KEY_W-1 -: BLOCK_W];
  assign round_out = perm_layer(sub_layer(mixed));

  // rotate right by 19
  assign rot = {key_in[18:0], key_in[KEY_W-1:19]};

  always_comb begin
    key_out = rot;
    key_out[KEY_W-1 -: 4] = sbox(rot[KEY_W-1 -: 4]);
    key_out[19:15] = rot[19:15] ^ rc;
  end

endmodule

// ===== rtl/core/present80_block_encrypt_unit.sv =====
// present-80 encrypt unit: round pipeline with apb key registers
// each accepted block passes through ROUNDS rounds (31 by default), then the final key addition
// throughput: one block per cycle while the output is not stalled, one unrolled round per pipeline stage
// a stall on the output freezes every stage at once, so in_ready follows the last stage
// reset: rst (synchronous) empties the pipeline and clears both key registers to zero
module present80_block_encrypt_unit #(
  parameter int ROUNDS = prs80_pkg::ROUNDS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [prs80_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [prs80_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [prs80_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  prs80_pkg::block_t                   plain_block,
  output logic                                out_valid,
  input  logic                                out_ready,
  output prs80_pkg::block_t                   cipher_block
);
  import prs80_pkg::*;

  logic [BLOCK_W-1:0]  key_low;
  logic [KEY_HI_W-1:0] key_high;

  logic        cfg_wr;
  reg_idx_t    cfg_sel;

  logic [ROUNDS:0] vld;
  block_t          st [ROUNDS+1];
  key_t            ky [ROUNDS+1];
  block_t          st_next [ROUNDS];
  key_t            ky_next [ROUNDS];
  logic            adv;

  // register interface
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = reg_idx_t'(paddr[APB_ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_KEY_LOW:  key_low  <= pwdata[BLOCK_W-1:0];
        REG_KEY_HIGH: key_high <= pwdata[KEY_HI_W-1:0];
        default:      key_low  <= key_low;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_KEY_LOW:  prdata = APB_DATA_W'(key_low);
      REG_KEY_HIGH: prdata = APB_DATA_W'(key_high);
      default:      prdata = '0;
    endcase
  end

  // pipeline moves whenever the last stage is empty or being taken
  assign adv      = !vld[ROUNDS] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ROUNDS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= plain_block;
      ky[0] <= {key_high, key_low};
    end
  end

  for (genvar s = 0; s < ROUNDS; s++) begin : g_round
    prs80_round u_round (
      .state_in  (st[s]),
      .key_in    (ky[s]),
      .rc        (RC_W'(s + 1)),
      .round_out (st_next[s]),
      .key_out   (ky_next[s])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        st[s+1] <= st_next[s];
        ky[s+1] <= ky_next[s];
      end
    end
  end

  // final key addition
  assign out_valid    = vld[ROUNDS];
  assign cipher_block = st[ROUNDS] ^ ky[ROUNDS][KEY_W-1 -: BLOCK_W];

`ifndef SYNTHESIS
  a_accept_fills_first: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> vld[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld) && $stable(cipher_block))
    else $error("pipeline moved during an output stall");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> vld == '0)
    else $error("pipeline not empty after reset");

  a_no_accept_no_fill: assert property (@(posedge clk) disable iff (rst)
    adv && !in_valid |=> !vld[0])
    else $error("first stage filled without a request");
`endif

endmodule
